@@ hw/rtl/vbe_pkg.sv @@
// Shared types and constants for the VPIN volume bucket engine.
// No dependencies; the other files, vbe_ring apart, take their names from here by scope.
`default_nettype none
package vbe_pkg;

	// Default sizes handed down as top-level parameter defaults
	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int WINDOW_MAX_DEF  = 64;

	// Stored ring position is kept at the width the largest window needs
	localparam int POS_MAX_W = 8;

	// Q1.16 full scale
	localparam logic [16:0] Q16_ONE = 17'h10000;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		CFG_BUCKET_VOLUME = 2'd0,
		CFG_TIME_BAR      = 2'd1,
		CFG_WINDOW        = 2'd2,
		CFG_MIN_READY     = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic [39:0] BUCKET_VOLUME_RST = 40'd10000;
	localparam logic [63:0] TIME_BAR_RST      = 64'd60000000000;
	localparam logic [6:0]  WINDOW_RST        = 7'd50;
	localparam logic [7:0]  MIN_READY_RST     = 8'd10;

	// Item kinds and trade sides
	localparam logic       OP_TRADE  = 1'b0;
	localparam logic       OP_QUOTE  = 1'b1;
	localparam logic [1:0] CLS_SPLIT = 2'd0;
	localparam logic [1:0] CLS_BUY   = 2'd1;
	localparam logic [1:0] CLS_SELL  = 2'd2;

	// Per-symbol record held in the symbol store
	typedef struct packed {
		logic [39:0]          tot;
		logic [40:0]          buy;
		logic [40:0]          sell;
		logic [63:0]          start;
		logic [31:0]          cnt;
		logic [63:0]          pvs;
		logic [31:0]          bid;
		logic [31:0]          ask;
		logic                 qs;
		logic [POS_MAX_W-1:0] pos;
		logic [7:0]           ccount;
	} rec_t;

	// Request to the serial divider: remainder preload, dividend bits MSB first
	typedef struct packed {
		logic        start;
		logic [5:0]  steps;
		logic [63:0] rem_init;
		logic [63:0] bits;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/vbe_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on vbe_pkg for the request and response structs.
`default_nettype none
module vbe_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vbe_pkg::div_req_t req,
	output vbe_pkg::div_rsp_t  rsp
);

	logic [63:0] rem_q;
	logic [63:0] bits_q;
	logic [63:0] div_q;
	logic [31:0] quot_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] r2;
	logic [64:0] r2_sub;
	logic        ge;

	// Trial subtract of the shifted remainder
	always_comb begin
		r2     = {rem_q, bits_q[63]};
		r2_sub = r2 - {1'b0, div_q};
		ge     = (r2 >= {1'b0, div_q});
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			bits_q <= req.bits;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? r2_sub[63:0] : r2[63:0];
			bits_q <= {bits_q[62:0], 1'b0};
			quot_q <= {quot_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire

@@ hw/rtl/vbe_sym_store.sv @@
// Per-symbol record memory with registered read.
// Valid bits cleared by reset make unwritten records read as zero; uses vbe_pkg.
`default_nettype none
module vbe_sym_store #(
	parameter int NUM_SYMBOLS = vbe_pkg::NUM_SYMBOLS_DEF,
	parameter int SYM_W       = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [SYM_W-1:0] rd_addr,
	output vbe_pkg::rec_t         rd_rec,
	input  wire logic             wr_en,
	input  wire logic [SYM_W-1:0] wr_addr,
	input  wire vbe_pkg::rec_t    wr_rec
);

	vbe_pkg::rec_t          mem [NUM_SYMBOLS];
	vbe_pkg::rec_t          rd_q;
	logic [NUM_SYMBOLS-1:0] valid_q;
	logic                   rd_valid_q;

	// Record array: write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Mark written records, sample validity with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_rec = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

@@ hw/rtl/vbe_ring.sv @@
// Imbalance ring memory: one write port, one registered read port.
// Entries are read only after being written, so there is no clearing; no dependencies.
`default_nettype none
module vbe_ring #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [16:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [16:0]        rd_data
);

	logic [16:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/vpin_volume_bucket_engine_core.sv @@
// Top level of the VPIN volume bucket engine: sequencer, configuration and output register.
// Uses vbe_pkg, vbe_sym_store, vbe_ring and vbe_div.
//
// Channel  Dir  Signals                     Word
// in       in   s_tvalid/s_tready/s_tdata   symbol, event_time, trade_price, trade_quantity,
//                s_tuser                     aggressor, bid, ask; tuser = opcode
// out      out  m_tvalid/m_tready/m_tdata   trade_class .. open_trade_count
// cfg      in   cfg_wen/cfg_addr/cfg_wdata  register index and value
//
// One word at a time: accept, record read, update and write back, then the shared
// serial divider for a closing imbalance and for the open VWAP, ring reads for the
// window sum and the divider again for its mean, then the hand-over to the output register.
// Reset clears per-symbol valid bits at once; no clearing pass is run.
// The next word is taken while a result still waits on a stalled output.
`default_nettype none
module vpin_volume_bucket_engine_core #(
	parameter int NUM_SYMBOLS = vbe_pkg::NUM_SYMBOLS_DEF,
	parameter int WINDOW_MAX  = vbe_pkg::WINDOW_MAX_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [7:0] symbol, [71:8] event_time, [103:72] trade_price, [135:104] trade_quantity,
	// [137:136] aggressor, [169:138] bid, [201:170] ask, [207:202] zero
	input  wire logic [207:0] s_tdata,
	// [0] opcode
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [1:0] trade_class, [2] bucket_closed, [19:3] closed_imbalance, [36:20] window_vpin,
	// [44:37] completed_count, [45] vpin_ready, [85:46] open_volume,
	// [126:86] open_buy_half, [167:127] open_sell_half, [199:168] open_vwap,
	// [231:200] open_trade_count
	output logic [231:0]      m_tdata,
	input  wire logic         cfg_wen,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [63:0]  cfg_wdata
);

	localparam int SYM_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int RING_DEPTH = NUM_SYMBOLS * WINDOW_MAX;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W      = 17 + $clog2(WINDOW_MAX + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL  = 9'b000000010,
		S_UPD  = 9'b000000100,
		S_IMB  = 9'b000001000,
		S_RING = 9'b000010000,
		S_VWAP = 9'b000100000,
		S_SUM  = 9'b001000000,
		S_MEAN = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [39:0] cfg_bvs_q;
	logic [63:0] cfg_tbar_q;
	logic [6:0]  cfg_win_q;
	logic [7:0]  cfg_minr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bvs_q  <= vbe_pkg::BUCKET_VOLUME_RST;
			cfg_tbar_q <= vbe_pkg::TIME_BAR_RST;
			cfg_win_q  <= vbe_pkg::WINDOW_RST;
			cfg_minr_q <= vbe_pkg::MIN_READY_RST;
		end else if (cfg_wen) begin
			unique case (vbe_pkg::cfg_idx_t'(cfg_addr))
				vbe_pkg::CFG_BUCKET_VOLUME: cfg_bvs_q  <= cfg_wdata[39:0];
				vbe_pkg::CFG_TIME_BAR:      cfg_tbar_q <= cfg_wdata;
				vbe_pkg::CFG_WINDOW:        cfg_win_q  <= cfg_wdata[6:0];
				vbe_pkg::CFG_MIN_READY:     cfg_minr_q <= cfg_wdata[7:0];
				default:                    cfg_minr_q <= cfg_minr_q;
			endcase
		end
	end

	// Symbol wrap table, worked out at elaboration
	logic [SYM_W-1:0] sym_map [256];
	for (genvar gi = 0; gi < 256; gi++) begin : g_map
		assign sym_map[gi] = SYM_W'(gi % NUM_SYMBOLS);
	end

	// Input capture
	logic             in_acc;
	logic             op_q;
	logic [SYM_W-1:0] sym_q;
	logic [63:0]      now_q;
	logic [31:0]      price_q;
	logic [31:0]      qty_q;
	logic [1:0]       aggr_q;
	logic [31:0]      bid_q;
	logic [31:0]      ask_q;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= s_tuser;
			sym_q   <= sym_map[s_tdata[7:0]];
			now_q   <= s_tdata[71:8];
			price_q <= s_tdata[103:72];
			qty_q   <= s_tdata[135:104];
			aggr_q  <= s_tdata[137:136];
			bid_q   <= s_tdata[169:138];
			ask_q   <= s_tdata[201:170];
		end
	end

	// Symbol store
	vbe_pkg::rec_t rd_rec;
	vbe_pkg::rec_t new_rec;
	logic          sym_wr;

	assign sym_wr = (state_q == S_UPD);

	vbe_sym_store #(
		.NUM_SYMBOLS(NUM_SYMBOLS),
		.SYM_W      (SYM_W)
	) u_sym (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc),
		.rd_addr(sym_map[s_tdata[7:0]]),
		.rd_rec (rd_rec),
		.wr_en  (sym_wr),
		.wr_addr(sym_q),
		.wr_rec (new_rec)
	);

	// Working registers
	vbe_pkg::rec_t    cur_q;
	logic [63:0]      pv_q;
	logic             closed_q;
	logic [1:0]       cls_q;
	logic [POS_W-1:0] pos_old_q;
	logic [16:0]      imb_q;
	logic [31:0]      vwap_q;
	logic [16:0]      mean_q;
	logic [8:0]       n_q;
	logic             ready_q;
	logic [POS_W-1:0] rd_pos_q;
	logic [8:0]       iss_q;
	logic             pend_s1;
	logic [SUM_W-1:0] sum_q;

	// Window size and count cap
	logic [8:0] w9;
	logic [8:0] weff;
	logic [9:0] cap10;
	logic [7:0] cap;

	always_comb begin
		w9    = {2'b0, cfg_win_q};
		weff  = (w9 == 9'd0) ? 9'd1 : ((w9 > 9'(WINDOW_MAX)) ? 9'(WINDOW_MAX) : w9);
		cap10 = {weff, 1'b0};
		cap   = (cap10 > 10'd255) ? 8'd255 : cap10[7:0];
	end

	// Trade update of the open bucket
	logic             is_trade;
	logic [63:0]      start_n;
	logic [40:0]      tot_sum;
	logic [39:0]      tot_n;
	logic [64:0]      pvs_sum;
	logic [63:0]      pvs_n;
	logic [32:0]      cnt_sum;
	logic [31:0]      cnt_n;
	logic [32:0]      mid;
	logic [1:0]       cls_n;
	logic [32:0]      add_b;
	logic [32:0]      add_s;
	logic [41:0]      buy_sum;
	logic [41:0]      sell_sum;
	logic [40:0]      buy_n;
	logic [40:0]      sell_n;
	logic             close_v;
	logic [63:0]      elapsed;
	logic             close_t;
	logic             closed_n;
	logic [40:0]      diff_n;
	logic [40:0]      den_n;
	logic             imb_go;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_adv;
	logic [8:0]       cc_inc;
	logic [7:0]       cc_cap;
	logic [7:0]       cc_fin;
	logic [8:0]       n_n;

	always_comb begin
		is_trade = (op_q == vbe_pkg::OP_TRADE);
		start_n  = (cur_q.cnt == 32'd0) ? now_q : cur_q.start;
		tot_sum  = {1'b0, cur_q.tot} + 41'(qty_q);
		tot_n    = tot_sum[40] ? '1 : tot_sum[39:0];
		pvs_sum  = {1'b0, cur_q.pvs} + {1'b0, pv_q};
		pvs_n    = pvs_sum[64] ? '1 : pvs_sum[63:0];
		cnt_sum  = {1'b0, cur_q.cnt} + 33'd1;
		cnt_n    = cnt_sum[32] ? '1 : cnt_sum[31:0];

		// Aggressor side first, then midpoint test, else even split
		mid   = ({1'b0, cur_q.bid} + {1'b0, cur_q.ask}) >> 1;
		cls_n = vbe_pkg::CLS_SPLIT;
		if (aggr_q == vbe_pkg::CLS_BUY || aggr_q == vbe_pkg::CLS_SELL) begin
			cls_n = aggr_q;
		end else if (cur_q.qs && cur_q.bid != 32'd0 && cur_q.ask != 32'd0) begin
			if ({1'b0, price_q} > mid) begin
				cls_n = vbe_pkg::CLS_BUY;
			end else if ({1'b0, price_q} < mid) begin
				cls_n = vbe_pkg::CLS_SELL;
			end
		end

		case (cls_n)
			vbe_pkg::CLS_BUY: begin
				add_b = {qty_q, 1'b0};
				add_s = '0;
			end
			vbe_pkg::CLS_SELL: begin
				add_b = '0;
				add_s = {qty_q, 1'b0};
			end
			default: begin
				add_b = {1'b0, qty_q};
				add_s = {1'b0, qty_q};
			end
		endcase
		buy_sum  = {1'b0, cur_q.buy} + 42'(add_b);
		sell_sum = {1'b0, cur_q.sell} + 42'(add_s);
		buy_n    = buy_sum[41] ? '1 : buy_sum[40:0];
		sell_n   = sell_sum[41] ? '1 : sell_sum[40:0];

		// Close on volume, else on age
		close_v  = (tot_n >= cfg_bvs_q);
		elapsed  = (now_q >= start_n) ? (now_q - start_n) : 64'd0;
		close_t  = (elapsed > cfg_tbar_q) && (tot_n != 40'd0);
		closed_n = is_trade && (close_v || close_t);

		diff_n = (buy_n > sell_n) ? (buy_n - sell_n) : (sell_n - buy_n);
		den_n  = {tot_n, 1'b0};
		imb_go = closed_n && (den_n != 41'd0) && ({2'b0, diff_n[40:2]} < den_n);

		pos_cur = cur_q.pos[POS_W-1:0];
		pos_adv = (pos_cur == POS_W'(WINDOW_MAX - 1)) ? '0 : (pos_cur + POS_W'(1));
		cc_inc  = {1'b0, cur_q.ccount} + 9'd1;
		cc_cap  = (cc_inc > {1'b0, cap}) ? cap : cc_inc[7:0];
		cc_fin  = closed_n ? cc_cap : cur_q.ccount;
		n_n     = (weff < {1'b0, cc_fin}) ? weff : {1'b0, cc_fin};

		// Record to write back
		new_rec = cur_q;
		if (!is_trade) begin
			new_rec.bid = bid_q;
			new_rec.ask = ask_q;
			new_rec.qs  = 1'b1;
		end else if (closed_n) begin
			new_rec.tot    = '0;
			new_rec.buy    = '0;
			new_rec.sell   = '0;
			new_rec.start  = '0;
			new_rec.cnt    = '0;
			new_rec.pvs    = '0;
			new_rec.pos    = vbe_pkg::POS_MAX_W'(pos_adv);
			new_rec.ccount = cc_cap;
		end else begin
			new_rec.tot   = tot_n;
			new_rec.buy   = buy_n;
			new_rec.sell  = sell_n;
			new_rec.start = start_n;
			new_rec.cnt   = cnt_n;
			new_rec.pvs   = pvs_n;
		end
	end

	// Shared divider
	vbe_pkg::div_req_t div_req;
	vbe_pkg::div_rsp_t div_rsp;
	logic              vwap_go;
	logic              sum_done;
	logic [8:0]        n_eff;

	assign vwap_go  = (cur_q.tot != 40'd0) && ({8'd0, cur_q.pvs[63:32]} < cur_q.tot);
	assign n_eff    = ready_q ? n_q : 9'd0;
	assign sum_done = (iss_q == n_eff) && !pend_s1;

	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_UPD: begin
				div_req.start    = imb_go;
				div_req.steps    = 6'd18;
				div_req.rem_init = 64'(diff_n[40:2]);
				div_req.bits     = {diff_n[1:0], 62'd0};
				div_req.divisor  = 64'(den_n);
			end
			S_RING: begin
				div_req.start    = vwap_go;
				div_req.steps    = 6'd32;
				div_req.rem_init = {32'd0, cur_q.pvs[63:32]};
				div_req.bits     = {cur_q.pvs[31:0], 32'd0};
				div_req.divisor  = 64'(cur_q.tot);
			end
			S_SUM: begin
				div_req.start    = sum_done && (n_eff != 9'd0);
				div_req.steps    = 6'(SUM_W);
				div_req.rem_init = '0;
				div_req.bits     = {sum_q, (64 - SUM_W)'(0)};
				div_req.divisor  = 64'(n_q);
			end
			default: div_req = '0;
		endcase
	end

	vbe_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Imbalance ring
	logic [16:0]       ring_rd;
	logic              ring_wr;
	logic              ring_re;
	logic [POS_W-1:0]  rd_pos_prev;
	logic [RING_AW-1:0] ring_wa;
	logic [RING_AW-1:0] ring_ra;

	always_comb begin
		ring_wr     = (state_q == S_RING) && closed_q;
		ring_re     = (state_q == S_SUM) && (iss_q < n_eff);
		rd_pos_prev = (rd_pos_q == '0) ? POS_W'(WINDOW_MAX - 1) : (rd_pos_q - POS_W'(1));
		ring_wa     = RING_AW'(sym_q) * RING_AW'(WINDOW_MAX) + RING_AW'(pos_old_q);
		ring_ra     = RING_AW'(sym_q) * RING_AW'(WINDOW_MAX) + RING_AW'(rd_pos_prev);
	end

	vbe_ring #(
		.DEPTH(RING_DEPTH),
		.AW   (RING_AW)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_wr),
		.wr_addr(ring_wa),
		.wr_data(imb_q),
		.rd_en  (ring_re),
		.rd_addr(ring_ra),
		.rd_data(ring_rd)
	);

	// Output register
	logic          m_valid_q;
	logic [231:0]  m_data_q;
	logic          out_load;

	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {cur_q.cnt, vwap_q, cur_q.sell, cur_q.buy, cur_q.tot, ready_q,
				cur_q.ccount, mean_q, imb_q, closed_q, cls_q};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= S_MUL;
				S_MUL:  state_q <= S_UPD;
				S_UPD:  state_q <= imb_go ? S_IMB : S_RING;
				S_IMB:  if (div_rsp.done) state_q <= S_RING;
				S_RING: state_q <= vwap_go ? S_VWAP : S_SUM;
				S_VWAP: if (div_rsp.done) state_q <= S_SUM;
				S_SUM: begin
					if (sum_done) begin
						state_q <= (n_eff != 9'd0) ? S_MEAN : S_FIN;
					end
				end
				S_MEAN: if (div_rsp.done) state_q <= S_FIN;
				S_FIN:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers along the sequence
	always_ff @(posedge clk) begin
		case (state_q)
			S_MUL: begin
				pv_q  <= price_q * qty_q;
				cur_q <= rd_rec;
			end
			S_UPD: begin
				cur_q     <= new_rec;
				closed_q  <= closed_n;
				cls_q     <= is_trade ? cls_n : vbe_pkg::CLS_SPLIT;
				pos_old_q <= pos_cur;
				imb_q     <= (closed_n && den_n != 41'd0) ? vbe_pkg::Q16_ONE : 17'd0;
				n_q       <= n_n;
				ready_q   <= (cc_fin >= cfg_minr_q);
				rd_pos_q  <= closed_n ? pos_adv : pos_cur;
				iss_q     <= '0;
				pend_s1   <= 1'b0;
				sum_q     <= '0;
				mean_q    <= '0;
			end
			S_IMB: begin
				if (div_rsp.done) begin
					imb_q <= (div_rsp.quot > 32'(vbe_pkg::Q16_ONE)) ?
						vbe_pkg::Q16_ONE : div_rsp.quot[16:0];
				end
			end
			S_RING: begin
				vwap_q <= (cur_q.tot == 40'd0) ? 32'd0 : '1;
			end
			S_VWAP: begin
				if (div_rsp.done) begin
					vwap_q <= div_rsp.quot;
				end
			end
			S_SUM: begin
				pend_s1 <= ring_re;
				if (ring_re) begin
					rd_pos_q <= rd_pos_prev;
					iss_q    <= iss_q + 9'd1;
				end
				if (pend_s1) begin
					sum_q <= sum_q + SUM_W'(ring_rd);
				end
			end
			S_MEAN: begin
				if (div_rsp.done) begin
					mean_q <= div_rsp.quot[16:0];
				end
			end
			default: begin
				pend_s1 <= 1'b0;
			end
		endcase
	end

	// Checks on the sequencer and result fields
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MUL))
		else $error("word accepted outside idle");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FIN))
		else $error("result raised without a finished word");

	a_imb_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:3] <= vbe_pkg::Q16_ONE))
		else $error("imbalance above full scale");

	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[45]) |-> (m_tdata[36:20] == 17'd0))
		else $error("window value shown while not ready");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_IMB || state_q == S_VWAP || state_q == S_MEAN))
		else $error("divider finished outside a wait state");

endmodule
`default_nettype wire
